// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rcts_pkg.sv
// ----------------------------------------------------------------------------
// rcts_pkg
// Word types and register indexes of the rectangle clip and tile splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcts_pkg;

  // Rectangle word taken on the command side
  typedef struct packed {
    logic        [15:0] in_x;
    logic        [15:0] in_y;
    logic        [15:0] in_w;
    logic        [15:0] in_h;
    logic signed [31:0] in_enc;
    logic        [15:0] in_src_x;
    logic        [15:0] in_src_y;
  } in_word_t;

  // Piece word given on the result side
  typedef struct packed {
    logic        [15:0] out_x;
    logic        [15:0] out_y;
    logic        [15:0] out_w;
    logic        [15:0] out_h;
    logic signed [31:0] out_enc;
    logic        [15:0] out_src_x;
    logic        [15:0] out_src_y;
    logic               out_last;
  } out_word_t;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_CLIP_X        = 3'd0,
    REG_CLIP_Y        = 3'd1,
    REG_CLIP_W        = 3'd2,
    REG_CLIP_H        = 3'd3,
    REG_SPLIT_ENABLE  = 3'd4,
    REG_COPYRECT_CODE = 3'd5
  } reg_index_t;

endpackage

`default_nettype wire

// File: rtl/core/rect_clip_and_tile_split.sv
// ----------------------------------------------------------------------------
// rect_clip_and_tile_split
// Clips rectangles to a window and cuts large ones on the tile grid.
// ----------------------------------------------------------------------------
// Usage:
//   Command side: a rectangle word on in_data is taken at a clock edge with
//   start high and busy low. Result side: each piece shows on out_data for
//   one cycle with out_strobe high; out_last marks the final piece of a
//   rectangle. A rectangle clipped to nothing gives no piece at all.
//   Configuration: APB-style port, registers at byte address 4*index.
//   Write it only while the block is empty.
// Pipeline and throughput:
//   A taken word passes stage 0, stages 1 to 3 and the emitter before its
//   first piece shows. A rectangle gives one, two or three pieces, one a
//   cycle, and the single result port sets the rate: a word every cycle
//   for one-piece rectangles; the pipe holds while later pieces go out.
//   busy rises while the piece emitter holds more pieces than the one now
//   shown and the input stage is full.
// Reset: rst (synchronous) empties the pipeline and restores the registers.
//   The receiver cannot stall: pieces are sent as soon as they are ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rect_clip_and_tile_split #(
  parameter int TILE_SIZE = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  // command side
  input  wire                     start,
  output logic                    busy,
  input  rcts_pkg::in_word_t      in_data,
  // result side
  output logic                    out_strobe,
  output rcts_pkg::out_word_t     out_data,
  // configuration port
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [4:0]              paddr,
  input  wire  [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import rcts_pkg::*;

  // Grid rounding: q = floor(n / TILE_SIZE) by reciprocal multiply, n < 2^17
  localparam int RECIP_SHIFT = 17 + $clog2(TILE_SIZE);
  localparam int RECIP_M     = (1 << RECIP_SHIFT) / TILE_SIZE + 1;
  localparam int RECIP_W     = $clog2(RECIP_M + 1);
  localparam int PROD_W      = 17 + RECIP_W;
  localparam int AREA_LIMIT  = TILE_SIZE * TILE_SIZE;

  typedef struct packed {
    logic        [15:0] x;
    logic        [15:0] y;
    logic        [16:0] xe;
    logic        [16:0] ye;
    logic        [15:0] rx;
    logic        [15:0] ry;
    logic signed [31:0] enc;
    logic        [15:0] src_x;
    logic        [15:0] src_y;
  } clip_stage_t;

  typedef struct packed {
    logic        [15:0]       x;
    logic        [15:0]       y;
    logic        [15:0]       w;
    logic        [15:0]       h;
    logic                     empty;
    logic                     is_copy;
    logic signed [31:0]       enc;
    logic        [15:0]       src_x;
    logic        [15:0]       src_y;
    logic        [31:0]       area;
    logic        [PROD_W-1:0] prod_x;
    logic        [PROD_W-1:0] prod_y;
  } size_stage_t;

  typedef struct packed {
    logic        [15:0] x;
    logic        [15:0] y;
    logic        [15:0] w;
    logic        [15:0] h;
    logic               empty;
    logic               is_copy;
    logic signed [31:0] enc;
    logic        [15:0] src_x;
    logic        [15:0] src_y;
    logic               area_big;
    logic        [15:0] xa;
    logic        [15:0] ya;
  } grid_stage_t;

  // Configuration registers
  logic        [15:0] clip_x;
  logic        [15:0] clip_y;
  logic        [15:0] clip_w;
  logic        [15:0] clip_h;
  logic               split_enable;
  logic signed [31:0] copyrect_code;

  // Pipeline registers
  logic        s0_valid;
  in_word_t    s0;
  logic        s1_valid;
  clip_stage_t s1;
  clip_stage_t s1_next;
  logic        s2_valid;
  size_stage_t s2;
  size_stage_t s2_next;
  logic        s3_valid;
  grid_stage_t s3;
  grid_stage_t s3_next;

  // Piece emitter
  logic        emit_valid;
  logic [1:0]  rem;
  out_word_t   pieces [3];
  out_word_t   built  [3];
  logic [1:0]  built_cnt;

  logic        adv;
  logic        accept;
  reg_index_t  reg_sel;
  logic        cfg_write;

  // Stage 1 helpers
  logic [16:0] rect_xe;
  logic [16:0] rect_ye;
  logic [16:0] win_xe;
  logic [16:0] win_ye;

  // Stage 2 helpers
  logic [17:0] w_full;
  logic [17:0] h_full;
  logic [16:0] round_x;
  logic [16:0] round_y;

  // Stage 3 helpers
  logic [16:0] qx;
  logic [16:0] qy;

  // Piece build helpers
  logic [18:0] bw_full;
  logic [18:0] bh_full;
  logic        split_go;
  out_word_t   whole_piece;
  out_word_t   top_piece;
  out_word_t   left_piece;
  out_word_t   body_piece;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_x        <= '0;
      clip_y        <= '0;
      clip_w        <= 16'hFFFF;
      clip_h        <= 16'hFFFF;
      split_enable  <= 1'b0;
      copyrect_code <= 32'sd1;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CLIP_X:        clip_x        <= pwdata[15:0];
        REG_CLIP_Y:        clip_y        <= pwdata[15:0];
        REG_CLIP_W:        clip_w        <= pwdata[15:0];
        REG_CLIP_H:        clip_h        <= pwdata[15:0];
        REG_SPLIT_ENABLE:  split_enable  <= pwdata[0];
        REG_COPYRECT_CODE: copyrect_code <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      REG_CLIP_X:        prdata = {16'h0000, clip_x};
      REG_CLIP_Y:        prdata = {16'h0000, clip_y};
      REG_CLIP_W:        prdata = {16'h0000, clip_w};
      REG_CLIP_H:        prdata = {16'h0000, clip_h};
      REG_SPLIT_ENABLE:  prdata = {31'h0, split_enable};
      REG_COPYRECT_CODE: prdata = copyrect_code;
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipe moves when the emitter frees up
  // --------------------------------------------------------------------------
  assign adv    = !emit_valid || (rem == 2'd1);
  assign busy   = s0_valid && !adv;
  assign accept = start && !busy;

  // Stage 0: hold the command word
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (accept) begin
      s0_valid <= 1'b1;
    end else if (adv) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0 <= in_data;
    end
  end

  // Stage 1: intersect with the clip window
  assign rect_xe = {1'b0, s0.in_x} + {1'b0, s0.in_w};
  assign rect_ye = {1'b0, s0.in_y} + {1'b0, s0.in_h};
  assign win_xe  = {1'b0, clip_x} + {1'b0, clip_w};
  assign win_ye  = {1'b0, clip_y} + {1'b0, clip_h};

  always_comb begin
    s1_next.x     = (s0.in_x > clip_x) ? s0.in_x : clip_x;
    s1_next.y     = (s0.in_y > clip_y) ? s0.in_y : clip_y;
    s1_next.xe    = (rect_xe < win_xe) ? rect_xe : win_xe;
    s1_next.ye    = (rect_ye < win_ye) ? rect_ye : win_ye;
    s1_next.rx    = s0.in_x;
    s1_next.ry    = s0.in_y;
    s1_next.enc   = s0.in_enc;
    s1_next.src_x = s0.in_src_x;
    s1_next.src_y = s0.in_src_y;
  end

  // Stage 2: extents, copy source shift, area and grid products
  assign w_full  = {1'b0, s1.xe} - {2'b00, s1.x};
  assign h_full  = {1'b0, s1.ye} - {2'b00, s1.y};
  assign round_x = {1'b0, s1.x} + 17'(TILE_SIZE - 1);
  assign round_y = {1'b0, s1.y} + 17'(TILE_SIZE - 1);

  always_comb begin
    s2_next.x       = s1.x;
    s2_next.y       = s1.y;
    s2_next.w       = w_full[15:0];
    s2_next.h       = h_full[15:0];
    s2_next.empty   = w_full[17] || (w_full == '0) || h_full[17] || (h_full == '0);
    s2_next.is_copy = (s1.enc == copyrect_code);
    s2_next.enc     = s1.enc;
    s2_next.src_x   = s2_next.is_copy ? s1.src_x + (s1.x - s1.rx) : '0;
    s2_next.src_y   = s2_next.is_copy ? s1.src_y + (s1.y - s1.ry) : '0;
    s2_next.area    = {16'h0000, w_full[15:0]} * {16'h0000, h_full[15:0]};
    s2_next.prod_x  = PROD_W'(round_x) * PROD_W'(RECIP_M);
    s2_next.prod_y  = PROD_W'(round_y) * PROD_W'(RECIP_M);
  end

  // Stage 3: area test and aligned corner
  assign qx = 17'(s2.prod_x >> RECIP_SHIFT);
  assign qy = 17'(s2.prod_y >> RECIP_SHIFT);

  always_comb begin
    s3_next.x        = s2.x;
    s3_next.y        = s2.y;
    s3_next.w        = s2.w;
    s3_next.h        = s2.h;
    s3_next.empty    = s2.empty;
    s3_next.is_copy  = s2.is_copy;
    s3_next.enc      = s2.enc;
    s3_next.src_x    = s2.src_x;
    s3_next.src_y    = s2.src_y;
    s3_next.area_big = s2.area > 32'(AREA_LIMIT);
    s3_next.xa       = 16'(qx * 17'(TILE_SIZE));
    s3_next.ya       = 16'(qy * 17'(TILE_SIZE));
  end

  // Advance stages 1 to 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
    end
  end

  // --------------------------------------------------------------------------
  // Piece build: whole rectangle, or top strip, left strip and body
  // --------------------------------------------------------------------------
  assign bw_full  = {3'b000, s3.w} + {3'b000, s3.x} - {3'b000, s3.xa};
  assign bh_full  = {3'b000, s3.h} + {3'b000, s3.y} - {3'b000, s3.ya};
  assign split_go = split_enable && !s3.is_copy && s3.area_big &&
                    !bw_full[18] && (bw_full >= 19'(TILE_SIZE)) &&
                    !bh_full[18] && (bh_full >= 19'(TILE_SIZE));

  always_comb begin
    whole_piece = '{out_x: s3.x, out_y: s3.y, out_w: s3.w, out_h: s3.h,
                    out_enc: s3.enc, out_src_x: s3.src_x, out_src_y: s3.src_y,
                    out_last: 1'b0};
    top_piece   = '{out_x: s3.x, out_y: s3.y, out_w: s3.w, out_h: s3.ya - s3.y,
                    out_enc: s3.enc, out_src_x: 16'h0000, out_src_y: 16'h0000,
                    out_last: 1'b0};
    left_piece  = '{out_x: s3.x, out_y: s3.ya, out_w: s3.xa - s3.x,
                    out_h: bh_full[15:0], out_enc: s3.enc, out_src_x: 16'h0000,
                    out_src_y: 16'h0000, out_last: 1'b0};
    body_piece  = '{out_x: s3.xa, out_y: s3.ya, out_w: bw_full[15:0],
                    out_h: bh_full[15:0], out_enc: s3.enc, out_src_x: 16'h0000,
                    out_src_y: 16'h0000, out_last: 1'b0};
  end

  always_comb begin
    built     = '{default: '0};
    built_cnt = 2'd0;
    if (s3_valid && !s3.empty) begin
      if (split_go) begin
        if (s3.ya != s3.y) begin
          built[built_cnt] = top_piece;
          built_cnt        = built_cnt + 2'd1;
        end
        if (s3.xa != s3.x) begin
          built[built_cnt] = left_piece;
          built_cnt        = built_cnt + 2'd1;
        end
        built[built_cnt] = body_piece;
        built_cnt        = built_cnt + 2'd1;
      end else begin
        built[0]  = whole_piece;
        built_cnt = 2'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Emitter: load a rectangle's pieces, then shift one out per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_valid <= 1'b0;
      rem        <= 2'd0;
    end else if (adv) begin
      emit_valid <= (built_cnt != 2'd0);
      rem        <= built_cnt;
    end else begin
      rem        <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pieces <= built;
    end else begin
      pieces[0] <= pieces[1];
      pieces[1] <= pieces[2];
    end
  end

  // Drive the current piece
  assign out_strobe = emit_valid;

  always_comb begin
    out_data          = pieces[0];
    out_data.out_last = (rem == 2'd1);
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `ASSERT_IMPLY(a_busy_needs_emit, clk, rst, busy, emit_valid && (rem != 2'd1), "busy without pending pieces")
  `ASSERT_IMPLY(a_strobe_has_rem, clk, rst, out_strobe, rem != 2'd0, "strobe with no piece left")
  `ASSERT_NEXT(a_pieces_continue, clk, rst, out_strobe && !out_data.out_last, out_strobe, "piece run broken before last")
  `ASSERT_NEXT(a_stall_holds_s3, clk, rst, emit_valid && (rem != 2'd1), $stable(s3_valid) && $stable(s3), "stage 3 moved while stalled")

endmodule

`default_nettype wire

// File: bench/rect_clip_and_tile_split_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_clip_and_tile_split_tb
// Self-checking bench for the rectangle clip and tile splitter. Rectangle
// words go in through the command handshake, and the clip window, splitting
// and copy code are set over the APB port between phases. A tracker class
// works out the pieces that each accepted rectangle must give, and checks
// every piece word on the result side against them, field by field.
// ----------------------------------------------------------------------------

module rect_clip_and_tile_split_tb;

  import rcts_pkg::*;

  localparam int TILE        = 16;
  localparam int SETTLE      = 8;     // cycles for a dropped rectangle to leave
  localparam int DRAIN_LIMIT = 200;
  localparam int IDLE_LIMIT  = 1000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 56;

  // Expected pieces and the register copy they are worked out from
  class piece_tracker;
    logic        [15:0] clip_x = 16'h0000;
    logic        [15:0] clip_y = 16'h0000;
    logic        [15:0] clip_w = 16'hFFFF;
    logic        [15:0] clip_h = 16'hFFFF;
    bit                 split_on = 1'b0;
    logic signed [31:0] copy_code = 32'sd1;
    out_word_t          pending_pieces[$];
    int                 pieces_per_rect[4];
    int                 copies;
    int                 checked;
    int                 errors;

    function void set_reg(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_CLIP_X:        clip_x = v[15:0];
        REG_CLIP_Y:        clip_y = v[15:0];
        REG_CLIP_W:        clip_w = v[15:0];
        REG_CLIP_H:        clip_h = v[15:0];
        REG_SPLIT_ENABLE:  split_on = v[0];
        REG_COPYRECT_CODE: copy_code = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_pieces.size();
    endfunction

    function void push_piece(out_word_t base, int px, int py, int pw, int ph);
      out_word_t p;
      p = base;
      p.out_x = px[15:0];
      p.out_y = py[15:0];
      p.out_w = pw[15:0];
      p.out_h = ph[15:0];
      pending_pieces.push_back(p);
    endfunction

    // Clip the rectangle, then cut it on the tile grid where allowed
    function void note_rect(in_word_t r);
      int        rx, ry, x, y, xe, ye, w, h, xa, ya, dx, dy, bw, bh, n0;
      out_word_t base;
      n0 = pending_pieces.size();
      rx = r.in_x;
      ry = r.in_y;
      x  = (rx > int'(clip_x)) ? rx : int'(clip_x);
      y  = (ry > int'(clip_y)) ? ry : int'(clip_y);
      xe = rx + int'(r.in_w);
      ye = ry + int'(r.in_h);
      if (xe > int'(clip_x) + int'(clip_w)) xe = int'(clip_x) + int'(clip_w);
      if (ye > int'(clip_y) + int'(clip_h)) ye = int'(clip_y) + int'(clip_h);
      w = xe - x;
      h = ye - y;
      if (w < 0 || h < 0) begin
        w = 0;
        h = 0;
      end
      if (w == 0 || h == 0) begin
        pieces_per_rect[0]++;
        return;
      end
      base = '0;
      base.out_enc = r.in_enc;
      // copy: shift the source by the clip's move of the origin, emit whole
      if (r.in_enc == copy_code) begin
        base.out_src_x = 16'(int'(r.in_src_x) + x - rx);
        base.out_src_y = 16'(int'(r.in_src_y) + y - ry);
        base.out_last  = 1'b1;
        push_piece(base, x, y, w, h);
        copies++;
        pieces_per_rect[1]++;
        return;
      end
      if (split_on && longint'(w) * longint'(h) > longint'(TILE * TILE)) begin
        xa = ((x + TILE - 1) / TILE * TILE) & 'hFFFF;
        ya = ((y + TILE - 1) / TILE * TILE) & 'hFFFF;
        dx = xa - x;
        dy = ya - y;
        if (w - dx >= TILE && h - dy >= TILE) begin
          bw = w - dx;
          bh = h - dy;
          if (ya != y) push_piece(base, x, y, w, ya - y);
          if (xa != x) push_piece(base, x, ya, xa - x, bh);
          push_piece(base, xa, ya, bw, bh);
          pending_pieces[pending_pieces.size() - 1].out_last = 1'b1;
          pieces_per_rect[pending_pieces.size() - n0]++;
          return;
        end
      end
      base.out_last = 1'b1;
      push_piece(base, x, y, w, h);
      pieces_per_rect[1]++;
    endfunction

    function void compare_field(string name, longint unsigned want,
                                longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_piece(out_word_t got);
      out_word_t want;
      if (pending_pieces.size() == 0) begin
        $error("piece x=0x%0h y=0x%0h w=0x%0h h=0x%0h with nothing expected",
               got.out_x, got.out_y, got.out_w, got.out_h);
        errors++;
        return;
      end
      want = pending_pieces.pop_front();
      checked++;
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_w", want.out_w, got.out_w);
      compare_field("out_h", want.out_h, got.out_h);
      compare_field("out_enc", $unsigned(want.out_enc), $unsigned(got.out_enc));
      compare_field("out_src_x", want.out_src_x, got.out_src_x);
      compare_field("out_src_y", want.out_src_y, got.out_src_y);
      compare_field("out_last", want.out_last, got.out_last);
    endfunction

    // Report and drop pieces that never came
    function void flush_leftover();
      if (pending_pieces.size() != 0) begin
        $error("%0d expected pieces never arrived", pending_pieces.size());
        errors++;
        pending_pieces.delete();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    in_data;
  logic        out_strobe;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  piece_tracker board;
  int           idle_cycles;
  int           phases_run;

  rect_clip_and_tile_split #(
    .TILE_SIZE (TILE)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every piece word at the edge that takes it
  always @(posedge clk) begin
    if (!rst && out_strobe) begin
      board.check_piece(out_data);
    end
  end

  // Count cycles with no word moving on any port
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_word_t rect(int x, int y, int w, int h, int enc,
                                    int sx, int sy);
    in_word_t r;
    r.in_x     = x[15:0];
    r.in_y     = y[15:0];
    r.in_w     = w[15:0];
    r.in_h     = h[15:0];
    r.in_enc   = enc;
    r.in_src_x = sx[15:0];
    r.in_src_y = sy[15:0];
    return r;
  endfunction

  // Coordinate mostly close to the clip origin so that the rectangle hits it
  function automatic logic [15:0] near(logic [15:0] c);
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'(16'hFFFF - $urandom_range(0, 40));
      default: return 16'(c + $urandom_range(0, 64) - $urandom_range(0, 24));
    endcase
  endfunction

  function automatic logic [15:0] extent();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom_range(0, TILE));
      1:       return 16'($urandom);
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(TILE, 120));
    endcase
  endfunction

  function automatic in_word_t make_rect();
    in_word_t r;
    int       pick;
    pick = $urandom_range(0, 9);
    r.in_x     = near(board.clip_x);
    r.in_y     = near(board.clip_y);
    r.in_w     = extent();
    r.in_h     = extent();
    r.in_src_x = 16'($urandom);
    r.in_src_y = 16'($urandom);
    if (pick < 3) begin
      r.in_enc = board.copy_code;
    end else if (pick == 3) begin
      r.in_enc = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    end else begin
      r.in_enc = $urandom;
    end
    return r;
  endfunction

  // Present one rectangle word and hold it until taken
  task automatic send_rect(input in_word_t r);
    start   = 1'b1;
    in_data = r;
    do @(posedge clk); while (busy);
    board.note_rect(r);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, v);
    @(negedge clk);
    // read back the register just written
    if (prdata !== v) begin
      $error("prdata: expected 0x%0h, got 0x%0h", v, prdata);
      board.errors++;
    end
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_clip(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] cw, input logic [15:0] ch,
                            input bit split, input logic [31:0] code);
    write_reg(REG_CLIP_X, {16'h0, cx});
    write_reg(REG_CLIP_Y, {16'h0, cy});
    write_reg(REG_CLIP_W, {16'h0, cw});
    write_reg(REG_CLIP_H, {16'h0, ch});
    write_reg(REG_SPLIT_ENABLE, {31'h0, split});
    write_reg(REG_COPYRECT_CODE, code);
    phases_run++;
  endtask

  // Wait for every expected piece, then let dropped rectangles clear
  task automatic drain();
    int n;
    for (n = 0; n < DRAIN_LIMIT && board.pending() != 0; n++) @(posedge clk);
    board.flush_leftover();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int left;
    int burst;
    bit paused;
    board       = new();
    phases_run  = 1;
    paused      = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: full window, no splitting, copy code 1
    send_rect(rect(0, 0, 0, 0, 0, 0, 0));
    send_rect(rect('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'h7FFFFFFF, 'hFFFF, 'hFFFF));
    send_rect(rect(10, 20, 30, 40, 0, 5, 6));
    send_rect(rect(100, 200, 50, 60, 1, 'hFFFF, 'hFFF0));
    send_rect(rect(0, 0, 'hFFFF, 'hFFFF, 'h80000000, 0, 0));
    send_rect(rect(3, 5, 100, 100, 2, 9, 9));
    drain();

    // Small window with splitting: source wrap, misses and every cut shape
    apply_clip(20, 30, 1000, 1000, 1'b1, 32'h80000000);
    send_rect(rect(5, 10, 100, 100, 'h80000000, 100, 'hFFF0));
    send_rect(rect(0, 0, 10, 10, 7, 0, 0));
    send_rect(rect(23, 37, 100, 100, 7, 1, 1));
    send_rect(rect(32, 48, 64, 64, 7, 0, 0));
    send_rect(rect(32, 37, 64, 64, 7, 0, 0));
    send_rect(rect(23, 48, 64, 64, 7, 0, 0));
    send_rect(rect(32, 48, 16, 16, 7, 0, 0));
    send_rect(rect(32, 48, 17, 16, 7, 0, 0));
    send_rect(rect(33, 48, 20, 20, 7, 0, 0));
    send_rect(rect(1010, 1020, 30, 30, 7, 0, 0));
    send_rect(rect(500, 500, 7, 'hFFFF, 7, 0, 0));
    drain();

    // Window at the top of the range: aligned coordinates wrap
    apply_clip(16'hFFF0, 16'hFFF0, 16'hFFFF, 16'hFFFF, 1'b1, 32'h7FFFFFFF);
    send_rect(rect('hFFFA, 'hFFF1, 5, 14, 3, 0, 0));
    send_rect(rect('hFFF1, 'hFFF1, 'hFFFF, 'hFFFF, 3, 0, 0));
    send_rect(rect('hFFFA, 'hFFFA, 100, 100, 'h7FFFFFFF, 1, 2));
    drain();

    // Empty window
    apply_clip(100, 100, 0, 50, 1'b1, 32'h1);
    send_rect(rect(100, 100, 50, 50, 5, 0, 0));
    drain();

    // Random phases, each under its own settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: apply_clip(16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 1'b1, 32'h7FFFFFFF);
        1: apply_clip(16'd12345, 16'd7, 16'd1, 16'hFFFF, 1'b1, 32'h80000000);
        2: apply_clip(16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0);
        default: begin
          apply_clip($urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom),
                     $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom),
                     $urandom_range(0, 2) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(32, 3000)),
                     $urandom_range(0, 2) == 0 ? 16'hFFFF
                                               : 16'($urandom_range(32, 3000)),
                     $urandom_range(0, 3) != 0,
                     $urandom_range(0, 1) ? 32'h1 : 32'($urandom));
        end
      endcase
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) burst = left;
        repeat (burst) send_rect(make_rect());
        left -= burst;
        // gap after most bursts, back to back otherwise
        if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        // hold off once until the block has sent everything
        if (ph == 3 && !paused && left < PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    $display("Rectangles taken over %0d settings: %0d clipped away, %0d whole,",
             phases_run, board.pieces_per_rect[0], board.pieces_per_rect[1]);
    $display("%0d cut in two, %0d cut in three, %0d copies; %0d pieces checked",
             board.pieces_per_rect[2], board.pieces_per_rect[3], board.copies,
             board.checked);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rcts_pkg.sv
rtl/core/rect_clip_and_tile_split.sv
bench/rect_clip_and_tile_split_tb.sv
